// ===== src/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by synchronous active-low reset
`define ASSERT_IMPL(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |-> (post)) \
    else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

// ===== src/ctxseg_pkg.sv =====
package ctxseg_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_TX_DONE  = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_ARB_LOST = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [31:0] id;
    logic [63:0] data;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [3:0]  FULL_LEN      = 4'd8;
  localparam int unsigned BYTES_PER_FRAME = 8;

endpackage

// ===== src/ctxseg_frame_queue.sv =====
`include "assert_macros.svh"

module ctxseg_frame_queue
  import ctxseg_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_ctrl_t          ctrl,
  input  frame_t           wr_frame,
  output frame_t           head,
  output logic [CNT_W-1:0] count
);

  frame_t             mem [DEPTH];
  frame_t             head_r;
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wp_nxt    = ctrl.push ? ptr_inc(wp_r) : wp_r;
    rp_nxt    = ctrl.pop ? ptr_inc(rp_r) : rp_r;
    count_nxt = count_r + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  // storage write and registered head read, bypassing a same-slot write
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wp_r] <= wr_frame;
    end
    if (ctrl.push && (wp_r == rp_nxt)) begin
      head_r <= wr_frame;
    end else begin
      head_r <= mem[rp_nxt];
    end
  end

  // empty queue: the frame written this cycle is the head
  assign head  = (count_r == '0) ? wr_frame : head_r;
  assign count = count_r;

  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_IMPL(a_no_push_full, clk, rst_n, ctrl.push, count_r != CNT_W'(DEPTH))
  `ASSERT_IMPL(a_pop_has_frame, clk, rst_n, ctrl.pop, (count_r != '0) || ctrl.push)

endmodule

// ===== src/can_tx_frame_segmenter_queue_top.sv =====
// can transmit segmenter with frame queue
// input channel: one beat per command (payload byte, transmit complete,
//   timer tick, arbitration lost) with message id, format flags and the byte
// result channel: exactly one beat per input beat, carrying the frame handed
//   to the controller (if any), resend and dropped flags and the queue level
// cfg port: cfg_wr_en writes the 16-bit timeout in ticks, reset value 3000
// path: an input beat is captured in the input register, then its result is
//   written to the result register when the beat is processed
// throughput: one beat per cycle unless stalled; each beat updates assembly,
//   at most one queue slot and the send handshake state in a single pass
// queue: a slot array with a registered head read and a write bypass
// stall: when out_stall holds the result register full, the pending input
//   beat waits in the input register and in_stall rises in turn
// reset: synchronous, clears the queue pointers, assembly, busy and timer;
//   slot contents are not cleared and need no clearing pass
`include "assert_macros.svh"

module can_tx_frame_segmenter_queue_top
  import ctxseg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH       = 16,
  parameter int unsigned MAX_MESSAGE_BYTES = 2048,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned LEN_W = $clog2(MAX_MESSAGE_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [28:0]      in_msg_id,
  input  logic             in_extended,
  input  logic             in_remote,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_load_frame,
  output logic [7:0]       out_frame_status,
  output logic [31:0]      out_frame_id,
  output logic [63:0]      out_frame_data,
  output logic             out_resend,
  output logic             out_dropped,
  output logic [CNT_W-1:0] out_queued_count,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data
);

  // input register
  logic        in_v_r;
  cmd_t        cmd_r;
  logic [28:0] id_r;
  logic        ext_r;
  logic        rem_r;
  logic [7:0]  byte_r;
  logic        last_r;

  // block state
  logic [15:0]      timeout_r;
  logic [63:0]      asm_r, asm_nxt;
  logic [2:0]       fill_r, fill_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             busy_r, busy_nxt;
  logic [15:0]      timer_r, timer_nxt;

  // result register
  logic             out_v_r;
  logic             load_r;
  frame_t           frame_r;
  logic             resend_r;
  logic             dropped_r;
  logic [CNT_W-1:0] qcount_r;

  // per-beat logic
  logic             fire;
  q_ctrl_t          q_ctrl;
  frame_t           push_frame;
  frame_t           head;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] count_after;
  logic             push_req;
  logic             load_req;
  logic             idle_if_empty;
  logic             full;
  logic             resend;
  logic             dropped;
  logic [63:0]      merged;
  logic [31:0]      aligned;
  logic [15:0]      timer_dec;
  logic             load;

  // a beat is processed whenever the result register is free or draining
  assign fire     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r  <= cmd_t'(in_cmd);
      id_r   <= in_msg_id;
      ext_r  <= in_extended;
      rem_r  <= in_remote;
      byte_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // extended ids sit at bit 3, standard ids at bit 21
  assign aligned = ext_r ? {id_r, 3'b000} : {id_r[10:0], 21'd0};
  assign full    = (q_count == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    asm_nxt       = asm_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    busy_nxt      = busy_r;
    timer_nxt     = timer_r;
    push_req      = 1'b0;
    push_frame    = '0;
    load_req      = 1'b0;
    idle_if_empty = 1'b0;
    resend        = 1'b0;
    dropped       = 1'b0;
    merged        = asm_r;
    timer_dec     = (timer_r != '0) ? timer_r - 16'd1 : '0;

    // drop the byte into the lane picked by the fill level
    for (int i = 0; i < BYTES_PER_FRAME; i++) begin
      if (fill_r == 3'(i)) begin
        merged[63 - 8 * i -: 8] = byte_r;
      end
    end

    if (fire) begin
      case (cmd_r)
        CMD_BYTE: begin
          if (rem_r) begin
            // remote message: one dataless frame, partial assembly discarded
            if (last_r) begin
              asm_nxt    = '0;
              fill_nxt   = '0;
              len_nxt    = '0;
              push_req   = 1'b1;
              push_frame = '{status: {ext_r, 1'b1, 6'd0}, id: aligned, data: 64'd0};
            end
          end else begin
            if (len_r >= LEN_W'(MAX_MESSAGE_BYTES)) begin
              dropped = 1'b1;
            end else begin
              len_nxt = len_r + LEN_W'(1);
              if (fill_r == 3'(BYTES_PER_FRAME - 1)) begin
                push_req   = 1'b1;
                push_frame = '{status: {ext_r, 3'd0, FULL_LEN}, id: aligned, data: merged};
                asm_nxt    = '0;
                fill_nxt   = '0;
              end else begin
                asm_nxt  = merged;
                fill_nxt = fill_r + 3'd1;
              end
            end
            if (last_r) begin
              // flush a short final frame
              if (fill_nxt != '0) begin
                push_req   = 1'b1;
                push_frame = '{status: {ext_r, 3'd0, 1'b0, fill_nxt}, id: aligned,
                               data: asm_nxt};
              end
              asm_nxt  = '0;
              fill_nxt = '0;
              len_nxt  = '0;
            end
          end
          load_req = last_r && !busy_r;
        end
        CMD_TX_DONE: begin
          load_req      = 1'b1;
          idle_if_empty = 1'b1;
        end
        CMD_TICK: begin
          if (busy_r) begin
            timer_nxt = timer_dec;
            if (timer_dec == '0) begin
              busy_nxt = 1'b0;
            end
          end
        end
        CMD_ARB_LOST: begin
          resend = 1'b1;
        end
        default: begin
          resend = 1'b0;
        end
      endcase
    end

    // queue full: frame is lost
    q_ctrl.push = push_req && !full;
    if (push_req && full) begin
      dropped = 1'b1;
    end

    // hand the head frame to the controller, possibly the one just queued
    load       = load_req && ((q_count != '0) || q_ctrl.push);
    q_ctrl.pop = load;
    if (load) begin
      busy_nxt  = 1'b1;
      timer_nxt = timeout_r;
    end else if (idle_if_empty) begin
      busy_nxt = 1'b0;
    end

    count_after = q_count + CNT_W'(q_ctrl.push) - CNT_W'(q_ctrl.pop);
  end

  ctxseg_frame_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (q_ctrl),
    .wr_frame (push_frame),
    .head     (head),
    .count    (q_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r   <= '0;
      fill_r  <= '0;
      len_r   <= '0;
      busy_r  <= 1'b0;
      timer_r <= '0;
    end else begin
      asm_r   <= asm_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      busy_r  <= busy_nxt;
      timer_r <= timer_nxt;
    end
  end

  // result register: fills on a processed beat, empties when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      load_r    <= load;
      frame_r   <= load ? head : '0;
      resend_r  <= resend;
      dropped_r <= dropped;
      qcount_r  <= count_after;
    end
  end

  assign out_valid        = out_v_r;
  assign out_load_frame   = load_r;
  assign out_frame_status = frame_r.status;
  assign out_frame_id     = frame_r.id;
  assign out_frame_data   = frame_r.data;
  assign out_resend       = resend_r;
  assign out_dropped      = dropped_r;
  assign out_queued_count = qcount_r;

  `ASSERT_NEXT(a_load_sets_busy, clk, rst_n, fire && load, busy_r)
  `ASSERT_NEXT(a_fire_fills_out, clk, rst_n, fire, out_v_r)
  `ASSERT_IMPL(a_empty_msg_no_fill, clk, rst_n, len_r == '0, fill_r == '0)

endmodule
